// ===== rtl/core/one_wire_master_slot_engine_core_assert.svh =====
// Assertion macros for the checker module of the 1-Wire slot engine
`ifndef ONE_WIRE_MASTER_SLOT_ENGINE_CORE_ASSERT_SVH
`define ONE_WIRE_MASTER_SLOT_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define OWM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("owm check failed");

// Next-cycle implication, disabled while reset is asserted
`define OWM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owm check failed");

`endif

// ===== rtl/core/owm_pkg.sv =====
// Shared types and constants of the 1-Wire slot engine
`default_nettype none
package owm_pkg;

	// Default width of the slot timer
	localparam int TIMER_WIDTH_DEF = 10;

	// Released ticks after a write-0 slot
	localparam int RECOVERY_TICKS = 5;

	// Command codes
	localparam logic [2:0] OP_RESET      = 3'd0;
	localparam logic [2:0] OP_WRITE_BIT  = 3'd1;
	localparam logic [2:0] OP_READ_BIT   = 3'd2;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd3;
	localparam logic [2:0] OP_READ_BYTE  = 3'd4;

	// Completion status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
	localparam logic [1:0] ST_LINE_LOW    = 2'd2;

	// Configuration register indexes
	localparam logic [3:0] CFG_RESET_LOW    = 4'd0;
	localparam logic [3:0] CFG_REL_MIN_WAIT = 4'd1;
	localparam logic [3:0] CFG_REL_TIMEOUT  = 4'd2;
	localparam logic [3:0] CFG_PRES_WINDOW  = 4'd3;
	localparam logic [3:0] CFG_READ_SAMPLE  = 4'd4;
	localparam logic [3:0] CFG_READ_SLOT    = 4'd5;
	localparam logic [3:0] CFG_WR_START_LOW = 4'd6;
	localparam logic [3:0] CFG_WR_HOLD      = 4'd7;

	// Bus phases
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_REL  = 3'd2,
		PH_PRESENCE = 3'd3,
		PH_WR_START = 3'd4,
		PH_WR_HOLD  = 3'd5,
		PH_WR_RECOV = 3'd6,
		PH_READ     = 3'd7
	} phase_t;

	// Timing configuration
	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [5:0] release_min_wait;
		logic [7:0] release_timeout;
		logic [9:0] presence_window;
		logic [3:0] read_sample_time;
		logic [6:0] read_slot_time;
		logic [3:0] write_start_low;
		logic [6:0] write_hold_time;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] rx_data;
	} res_t;

	// Register reset values
	localparam logic [9:0] RST_RESET_LOW    = 10'd500;
	localparam logic [5:0] RST_REL_MIN_WAIT = 6'd15;
	localparam logic [7:0] RST_REL_TIMEOUT  = 8'd60;
	localparam logic [9:0] RST_PRES_WINDOW  = 10'd480;
	localparam logic [3:0] RST_READ_SAMPLE  = 4'd10;
	localparam logic [6:0] RST_READ_SLOT    = 7'd65;
	localparam logic [3:0] RST_WR_START_LOW = 4'd2;
	localparam logic [6:0] RST_WR_HOLD      = 7'd60;

endpackage
`default_nettype wire

// ===== rtl/core/owm_cfg.sv =====
// Timing configuration registers of the 1-Wire slot engine
`default_nettype none
module owm_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [3:0]    cfg_addr,
	input  wire logic [9:0]    cfg_data,
	output owm_pkg::cfg_t      cfg
);

	owm_pkg::cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file, values truncated to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time   <= owm_pkg::RST_RESET_LOW;
			cfg_q.release_min_wait <= owm_pkg::RST_REL_MIN_WAIT;
			cfg_q.release_timeout  <= owm_pkg::RST_REL_TIMEOUT;
			cfg_q.presence_window  <= owm_pkg::RST_PRES_WINDOW;
			cfg_q.read_sample_time <= owm_pkg::RST_READ_SAMPLE;
			cfg_q.read_slot_time   <= owm_pkg::RST_READ_SLOT;
			cfg_q.write_start_low  <= owm_pkg::RST_WR_START_LOW;
			cfg_q.write_hold_time  <= owm_pkg::RST_WR_HOLD;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				owm_pkg::CFG_RESET_LOW:    cfg_q.reset_low_time   <= cfg_data;
				owm_pkg::CFG_REL_MIN_WAIT: cfg_q.release_min_wait <= cfg_data[5:0];
				owm_pkg::CFG_REL_TIMEOUT:  cfg_q.release_timeout  <= cfg_data[7:0];
				owm_pkg::CFG_PRES_WINDOW:  cfg_q.presence_window  <= cfg_data;
				owm_pkg::CFG_READ_SAMPLE:  cfg_q.read_sample_time <= cfg_data[3:0];
				owm_pkg::CFG_READ_SLOT:    cfg_q.read_slot_time   <= cfg_data[6:0];
				owm_pkg::CFG_WR_START_LOW: cfg_q.write_start_low  <= cfg_data[3:0];
				owm_pkg::CFG_WR_HOLD:      cfg_q.write_hold_time  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/owm_step.sv =====
// Next-state and result logic for one microsecond tick of the slot engine
`default_nettype none
module owm_step #(
	parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
	input  wire owm_pkg::cfg_t       cfg,
	input  wire logic                start_req,
	input  wire logic [2:0]          op,
	input  wire logic [7:0]          tx_data,
	input  wire logic                line_in,
	input  wire owm_pkg::phase_t     phase,
	input  wire logic [TIMER_WIDTH-1:0] slot_timer,
	input  wire logic [3:0]          bits_left,
	input  wire logic [7:0]          shift_reg,
	input  wire logic [2:0]          held_op,
	input  wire logic                presence_seen,
	output owm_pkg::phase_t          phase_nx,
	output logic [TIMER_WIDTH-1:0]   slot_timer_nx,
	output logic [3:0]               bits_left_nx,
	output logic [7:0]               shift_reg_nx,
	output logic [2:0]               held_op_nx,
	output logic                     presence_seen_nx,
	output owm_pkg::res_t            res
);

	localparam int TW = TIMER_WIDTH;

	// Last tick of a phase of length len (a zero length lasts one tick)
	function automatic logic ends(input logic [TW-1:0] t, input logic [TW-1:0] len);
		return ({1'b0, t} + {{TW{1'b0}}, 1'b1}) >= {1'b0, len};
	endfunction

	owm_pkg::phase_t ph;
	logic [TW-1:0]   t;
	logic [TW-1:0]   t_inc;
	logic [3:0]      bits;
	logic [7:0]      sh;
	logic [2:0]      hop;
	logic            pres;
	logic            bit_end;
	logic            slot_end;
	logic [TW-1:0]   sample_t;

	always_comb begin
		ph        = phase;
		t         = slot_timer;
		bits      = bits_left;
		sh        = shift_reg;
		hop       = held_op;
		pres      = presence_seen;
		bit_end   = 1'b0;
		slot_end  = 1'b0;
		sample_t  = TW'(cfg.read_sample_time);
		res       = '0;

		// Command start on an idle tick
		if (ph == owm_pkg::PH_IDLE && start_req && op <= owm_pkg::OP_READ_BYTE) begin
			hop  = op;
			pres = 1'b0;
			t    = '0;
			if (op == owm_pkg::OP_RESET) begin
				bits = 4'd0;
				sh   = 8'd0;
				ph   = owm_pkg::PH_RST_LOW;
			end else begin
				bits = (op >= owm_pkg::OP_WRITE_BYTE) ? 4'd8 : 4'd1;
				sh   = (op == owm_pkg::OP_WRITE_BIT || op == owm_pkg::OP_WRITE_BYTE) ?
					tx_data : 8'd0;
				ph   = (op == owm_pkg::OP_READ_BIT || op == owm_pkg::OP_READ_BYTE) ?
					owm_pkg::PH_READ : owm_pkg::PH_WR_START;
			end
		end

		// Saturating timer step
		t_inc = (t != {TW{1'b1}}) ? t + {{(TW-1){1'b0}}, 1'b1} : t;

		phase_nx      = ph;
		slot_timer_nx = t_inc;

		if (ph != owm_pkg::PH_IDLE) begin
			res.busy_res = 1'b1;
			unique case (ph)
				owm_pkg::PH_RST_LOW: begin
					res.drive_low = 1'b1;
					if (ends(t, TW'(cfg.reset_low_time))) begin
						phase_nx      = owm_pkg::PH_RST_REL;
						slot_timer_nx = '0;
					end
				end
				owm_pkg::PH_RST_REL: begin
					if (t >= TW'(cfg.release_min_wait) && line_in) begin
						phase_nx      = owm_pkg::PH_PRESENCE;
						slot_timer_nx = '0;
					end else if (t > TW'(cfg.release_timeout)) begin
						res.done_res  = 1'b1;
						res.status    = owm_pkg::ST_LINE_LOW;
						phase_nx      = owm_pkg::PH_IDLE;
						slot_timer_nx = '0;
					end
				end
				owm_pkg::PH_PRESENCE: begin
					if (!line_in) pres = 1'b1;
					if (ends(t, TW'(cfg.presence_window))) begin
						res.done_res  = 1'b1;
						res.status    = pres ? owm_pkg::ST_OK : owm_pkg::ST_NO_PRESENCE;
						phase_nx      = owm_pkg::PH_IDLE;
						slot_timer_nx = '0;
					end
				end
				owm_pkg::PH_WR_START: begin
					res.drive_low = 1'b1;
					if (ends(t, TW'(cfg.write_start_low))) begin
						phase_nx      = owm_pkg::PH_WR_HOLD;
						slot_timer_nx = '0;
					end
				end
				owm_pkg::PH_WR_HOLD: begin
					res.drive_low = !sh[0];
					if (ends(t, TW'(cfg.write_hold_time))) begin
						if (sh[0]) begin
							bit_end = 1'b1;
						end else begin
							phase_nx      = owm_pkg::PH_WR_RECOV;
							slot_timer_nx = '0;
						end
					end
				end
				owm_pkg::PH_WR_RECOV: begin
					if (ends(t, TW'(owm_pkg::RECOVERY_TICKS))) bit_end = 1'b1;
				end
				owm_pkg::PH_READ: begin
					slot_end      = ends(t, TW'(cfg.read_slot_time));
					res.drive_low = (t == '0);
					// Sample at the sample point, or on the last tick if the slot is short
					if (t == sample_t || (slot_end && t < sample_t))
						sh = {line_in, sh[7:1]};
					if (slot_end) begin
						bits          = bits - 4'd1;
						slot_timer_nx = '0;
						if (bits == 4'd0) begin
							res.done_res = 1'b1;
							res.rx_data  = (hop == owm_pkg::OP_READ_BYTE) ? sh : {7'd0, sh[7]};
							phase_nx     = owm_pkg::PH_IDLE;
						end else begin
							phase_nx = owm_pkg::PH_READ;
						end
					end
				end
				default: ;
			endcase

			// End of a write slot: next bit or done
			if (bit_end) begin
				bits          = bits - 4'd1;
				slot_timer_nx = '0;
				if (bits == 4'd0) begin
					res.done_res = 1'b1;
					phase_nx     = owm_pkg::PH_IDLE;
				end else begin
					sh       = {1'b0, sh[7:1]};
					phase_nx = owm_pkg::PH_WR_START;
				end
			end
		end

		bits_left_nx     = bits;
		shift_reg_nx     = sh;
		held_op_nx       = hop;
		presence_seen_nx = pres;
	end

endmodule
`default_nettype wire

// ===== rtl/core/one_wire_master_slot_engine_core.sv =====
// Top level of the 1-Wire bus master slot engine
//
//  port group   dir  payload (lsb first)
//  s_*          in   tdata: start_req, tx_data[7:0], line_in; tuser: op[2:0]
//  m_*          out  tdata: drive_low, busy_res, done_res, status[1:0], rx_data[7:0]
//  cfg_*        in   cfg_addr register index, cfg_data value
//
// One tick is taken per cycle unless the result is stalled: a tick is registered
// on input, then the phase logic updates the bus state and writes the result
// register once the result register is free or drains. The input register and the
// result register decouple the two sides, so a stalled result holds one tick back.
// arst_n resets state, valid flags and configuration to defaults, not data registers.
`default_nettype none
module one_wire_master_slot_engine_core #(
	parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // start_req, tx_data[7:0], line_in, zero pad
	input  wire logic [2:0]  s_tuser,   // op[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // drive_low, busy_res, done_res, status, rx_data, pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_addr,
	input  wire logic [9:0]  cfg_data
);

	owm_pkg::cfg_t   cfg;
	owm_pkg::res_t   res;

	logic            valid_s1;
	logic            start_s1;
	logic [2:0]      op_s1;
	logic [7:0]      tx_s1;
	logic            line_s1;
	logic            advance;

	owm_pkg::phase_t         phase_q, phase_nx;
	logic [TIMER_WIDTH-1:0]  timer_q, timer_nx;
	logic [3:0]              bits_q, bits_nx;
	logic [7:0]              shreg_q, shreg_nx;
	logic [2:0]              held_q, held_nx;
	logic                    pres_q, pres_nx;

	logic                    valid_s2;
	owm_pkg::res_t           res_s2;

	owm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: the tick in s1 moves on when the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tdata[0];
			tx_s1    <= s_tdata[8:1];
			line_s1  <= s_tdata[9];
			op_s1    <= s_tuser;
		end
	end

	owm_step #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_step (
		.cfg              (cfg),
		.start_req        (start_s1),
		.op               (op_s1),
		.tx_data          (tx_s1),
		.line_in          (line_s1),
		.phase            (phase_q),
		.slot_timer       (timer_q),
		.bits_left        (bits_q),
		.shift_reg        (shreg_q),
		.held_op          (held_q),
		.presence_seen    (pres_q),
		.phase_nx         (phase_nx),
		.slot_timer_nx    (timer_nx),
		.bits_left_nx     (bits_nx),
		.shift_reg_nx     (shreg_nx),
		.held_op_nx       (held_nx),
		.presence_seen_nx (pres_nx),
		.res              (res)
	);

	// Bus state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owm_pkg::PH_IDLE;
			timer_q <= '0;
			bits_q  <= 4'd0;
			shreg_q <= 8'd0;
			held_q  <= 3'd0;
			pres_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_nx;
			timer_q <= timer_nx;
			bits_q  <= bits_nx;
			shreg_q <= shreg_nx;
			held_q  <= held_nx;
			pres_q  <= pres_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, res_s2.rx_data, res_s2.status, res_s2.done_res,
		res_s2.busy_res, res_s2.drive_low};

endmodule
`default_nettype wire

// ===== rtl/core/owm_checker.sv =====
// Port-level checks of the 1-Wire slot engine, bound to the top level
`default_nettype none
`include "one_wire_master_slot_engine_core_assert.svh"
module owm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// A stalled result holds
	`OWM_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Completion only inside a command
	`OWM_ASSERT_IMP(a_done_busy, clk, arst_n, m_tvalid && m_tdata[2], m_tdata[1])

	// Status and received data are zero except on completion
	`OWM_ASSERT_IMP(a_status_done, clk, arst_n, m_tvalid && m_tdata[4:3] != 2'd0, m_tdata[2])
	`OWM_ASSERT_IMP(a_rx_done, clk, arst_n, m_tvalid && m_tdata[12:5] != 8'd0, m_tdata[2])

	// The bus is never pulled low while idle
	`OWM_ASSERT_IMP(a_drive_busy, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[1])

endmodule

bind one_wire_master_slot_engine_core owm_checker u_owm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
